@@ rtl/core/rmd_pkg.sv @@
// rmd_pkg: shared types, constants and step tables of the ripemd-160 engine
// no dependencies; imported by the round unit, the top level and the bench

package rmd_pkg;

	localparam int BUF_WORDS = 16;
	localparam int BUF_AW    = $clog2(BUF_WORDS);
	localparam int ROUNDS    = 80;
	localparam int RND_W     = $clog2(ROUNDS);
	localparam int DIG_WORDS = 5;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last_byte;
	} msg_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} dig_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} line_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_COMP,
		ST_FIN,
		ST_OUT
	} state_t;

	localparam logic [31:0] IV [DIG_WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [31:0] KL [5] = '{
		32'h00000000, 32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hA953FD4E
	};

	localparam logic [31:0] KR [5] = '{
		32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3, 32'h7A6D76E9, 32'h00000000
	};

	localparam logic [3:0] WL [ROUNDS] = '{
		4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
		4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
		4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3,
		4'd12, 4'd0, 4'd9, 4'd5, 4'd2, 4'd14, 4'd11, 4'd8,
		4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1,
		4'd2, 4'd7, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd12,
		4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4,
		4'd13, 4'd3, 4'd7, 4'd15, 4'd14, 4'd5, 4'd6, 4'd2,
		4'd4, 4'd0, 4'd5, 4'd9, 4'd7, 4'd12, 4'd2, 4'd10,
		4'd14, 4'd1, 4'd3, 4'd8, 4'd11, 4'd6, 4'd15, 4'd13
	};

	localparam logic [3:0] WR [ROUNDS] = '{
		4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4,
		4'd13, 4'd6, 4'd15, 4'd8, 4'd1, 4'd10, 4'd3, 4'd12,
		4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10,
		4'd14, 4'd15, 4'd8, 4'd12, 4'd4, 4'd9, 4'd1, 4'd2,
		4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9,
		4'd11, 4'd8, 4'd12, 4'd2, 4'd10, 4'd0, 4'd4, 4'd13,
		4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0,
		4'd5, 4'd12, 4'd2, 4'd13, 4'd9, 4'd7, 4'd10, 4'd14,
		4'd12, 4'd15, 4'd10, 4'd4, 4'd1, 4'd5, 4'd8, 4'd7,
		4'd6, 4'd2, 4'd13, 4'd14, 4'd0, 4'd3, 4'd9, 4'd11
	};

	localparam logic [3:0] SL [ROUNDS] = '{
		4'd11, 4'd14, 4'd15, 4'd12, 4'd5, 4'd8, 4'd7, 4'd9,
		4'd11, 4'd13, 4'd14, 4'd15, 4'd6, 4'd7, 4'd9, 4'd8,
		4'd7, 4'd6, 4'd8, 4'd13, 4'd11, 4'd9, 4'd7, 4'd15,
		4'd7, 4'd12, 4'd15, 4'd9, 4'd11, 4'd7, 4'd13, 4'd12,
		4'd11, 4'd13, 4'd6, 4'd7, 4'd14, 4'd9, 4'd13, 4'd15,
		4'd14, 4'd8, 4'd13, 4'd6, 4'd5, 4'd12, 4'd7, 4'd5,
		4'd11, 4'd12, 4'd14, 4'd15, 4'd14, 4'd15, 4'd9, 4'd8,
		4'd9, 4'd14, 4'd5, 4'd6, 4'd8, 4'd6, 4'd5, 4'd12,
		4'd9, 4'd15, 4'd5, 4'd11, 4'd6, 4'd8, 4'd13, 4'd12,
		4'd5, 4'd12, 4'd13, 4'd14, 4'd11, 4'd8, 4'd5, 4'd6
	};

	localparam logic [3:0] SR [ROUNDS] = '{
		4'd8, 4'd9, 4'd9, 4'd11, 4'd13, 4'd15, 4'd15, 4'd5,
		4'd7, 4'd7, 4'd8, 4'd11, 4'd14, 4'd14, 4'd12, 4'd6,
		4'd9, 4'd13, 4'd15, 4'd7, 4'd12, 4'd8, 4'd9, 4'd11,
		4'd7, 4'd7, 4'd12, 4'd7, 4'd6, 4'd15, 4'd13, 4'd11,
		4'd9, 4'd7, 4'd15, 4'd11, 4'd8, 4'd6, 4'd6, 4'd14,
		4'd12, 4'd13, 4'd5, 4'd14, 4'd13, 4'd13, 4'd7, 4'd5,
		4'd15, 4'd5, 4'd8, 4'd11, 4'd14, 4'd14, 4'd6, 4'd14,
		4'd6, 4'd9, 4'd12, 4'd9, 4'd12, 4'd5, 4'd15, 4'd8,
		4'd8, 4'd5, 4'd12, 4'd9, 4'd12, 4'd5, 4'd14, 4'd6,
		4'd8, 4'd13, 4'd6, 4'd5, 4'd15, 4'd13, 4'd11, 4'd11
	};

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [3:0] n);
		logic [63:0] t;
		t = {x, x} << n;
		return t[63:32];
	endfunction

	function automatic logic [31:0] boolfn(input logic [2:0] sel, input logic [31:0] x,
			input logic [31:0] y, input logic [31:0] z);
		logic [31:0] f;
		case (sel)
			3'd0: f = x ^ y ^ z;
			3'd1: f = (x & y) | (~x & z);
			3'd2: f = (x | ~y) ^ z;
			3'd3: f = (x & z) | (y & ~z);
			default: f = x ^ (y | ~z);
		endcase
		return f;
	endfunction

endpackage

@@ rtl/core/rmd_ram.sv @@
// rmd_ram: generic ram, one write port and two registered read ports
// no dependencies

module rmd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

@@ rtl/core/rmd_round.sv @@
// rmd_round: one step of one compression line
// depends on rmd_pkg for the line type, rotate and boolean functions

module rmd_round
	import rmd_pkg::*;
(
	input  line_t       cur,
	input  logic [31:0] w,
	input  logic [31:0] k,
	input  logic [2:0]  fsel,
	input  logic [3:0]  shamt,
	output line_t       nxt
);

	logic [31:0] sum;

	assign sum   = cur.a + boolfn(fsel, cur.b, cur.c, cur.d) + w + k;
	assign nxt.a = cur.e;
	assign nxt.b = rotl(sum, shamt) + cur.e;
	assign nxt.c = cur.b;
	assign nxt.d = rotl(cur.c, 4'd10);
	assign nxt.e = cur.d;

endmodule

@@ rtl/core/ripemd160_hash_engine_top.sv @@
// ripemd160_hash_engine_top: byte-stream ripemd-160 engine with padding and digest output
// depends on rmd_pkg, rmd_ram and rmd_round
//
//  channel | direction | handshake            | payload
//  msg     | in        | msg_valid, msg_stall | msg_t: data_byte, has_byte, last_byte
//  dig     | out       | dig_valid, dig_stall | dig_t: digest_word, word_index, last_word
//
// a byte item is taken in the cycle it is offered while idle; the item that fills the block
// starts a compression (one load, 80 steps of both lines in the two round units, one chaining update)
// an ending item adds 16 - pos/4 pad-word writes (pos counts its own byte) and a compression,
// another 16 writes and a compression when pos is 56 or more, a compression in front when its byte
// fills the block; then the five digest words enter the output register one by one
// arst_n clears control, the byte position and the bit count, and loads the chaining words with the IV
// msg_stall is high whenever the sequencer is busy; dig_stall holds the output register

module ripemd160_hash_engine_top
	import rmd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic msg_valid,
	output logic msg_stall,
	input  msg_t msg,
	output logic dig_valid,
	input  logic dig_stall,
	output dig_t dig
);

	// sequencer and message bookkeeping
	state_t            state_q, state_d;
	logic [5:0]        pos_q;
	logic [63:0]       bits_q;
	logic [23:0]       acc_q;
	logic [BUF_AW-1:0] wptr_q;
	logic              first_q;
	logic              extra_q;
	logic              fin_q;
	logic              lendone_q;
	logic [RND_W-1:0]  rnd_q;
	logic [2:0]        oidx_q;
	logic [31:0]       chain_q [DIG_WORDS];
	line_t             left_q, right_q;
	line_t             left_nxt, right_nxt;
	dig_t              out_q;
	logic              out_vld_q;

	logic              accept;
	logic              blk_full;
	logic [5:0]        new_pos;
	logic              load_out;

	// block buffer port signals
	logic              ram_we;
	logic [BUF_AW-1:0] ram_waddr;
	logic [31:0]       ram_wdata;
	logic [BUF_AW-1:0] ram_ra, ram_rb;
	logic [31:0]       ram_da, ram_db;
	logic [RND_W-1:0]  rnd_rd;
	logic [31:0]       pad_word;
	logic [31:0]       acc_ext;

	logic [2:0]        grp;

	assign msg_stall = (state_q != ST_IDLE);
	assign accept    = msg_valid && (state_q == ST_IDLE);
	assign blk_full  = accept && msg.has_byte && (pos_q == 6'd63);
	assign new_pos   = msg.has_byte ? pos_q + 6'd1 : pos_q;
	assign load_out  = (state_q == ST_OUT) && (!out_vld_q || !dig_stall);
	assign dig_valid = out_vld_q;
	assign dig       = out_q;

	// step group selects the boolean function and constants of both lines
	assign grp = rnd_q[RND_W-1:4];

	// message words live in a 16 x 32 buffer, both lines read it each step
	rmd_ram #(
		.WIDTH(32),
		.DEPTH(BUF_WORDS)
	) u_buf (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.raddr_a(ram_ra),
		.raddr_b(ram_rb),
		.rdata_a(ram_da),
		.rdata_b(ram_db)
	);

	rmd_round u_left (
		.cur  (left_q),
		.w    (ram_da),
		.k    (KL[grp]),
		.fsel (grp),
		.shamt(SL[rnd_q]),
		.nxt  (left_nxt)
	);

	rmd_round u_right (
		.cur  (right_q),
		.w    (ram_db),
		.k    (KR[grp]),
		.fsel (3'd4 - grp),
		.shamt(SR[rnd_q]),
		.nxt  (right_nxt)
	);

	// first pad word: pending bytes, then 0x80, then zeros
	assign acc_ext = {8'h00, acc_q};
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			if (2'(k) < pos_q[1:0]) begin
				pad_word[8*k +: 8] = acc_ext[8*k +: 8];
			end else if (2'(k) == pos_q[1:0]) begin
				pad_word[8*k +: 8] = 8'h80;
			end else begin
				pad_word[8*k +: 8] = 8'h00;
			end
		end
	end

	// read one step ahead, the buffer read is registered
	assign rnd_rd = (rnd_q == RND_W'(ROUNDS - 1)) ? '0 : rnd_q + 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (blk_full) begin
					state_d = ST_LOAD;
				end else if (accept && msg.last_byte) begin
					state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				if (wptr_q == BUF_AW'(BUF_WORDS - 1)) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: state_d = ST_COMP;
			ST_COMP: begin
				if (rnd_q == RND_W'(ROUNDS - 1)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!fin_q) begin
					state_d = ST_IDLE;
				end else if (lendone_q) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_PAD;
				end
			end
			ST_OUT: begin
				if (load_out && oidx_q == 3'(DIG_WORDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// buffer write and read addressing
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wptr_q;
		ram_wdata = 32'h0;
		ram_ra    = '0;
		ram_rb    = '0;
		case (state_q)
			ST_IDLE: begin
				// a word is written once its fourth byte arrives
				if (accept && msg.has_byte && pos_q[1:0] == 2'd3) begin
					ram_we    = 1'b1;
					ram_waddr = pos_q[5:2];
					ram_wdata = {msg.data_byte, acc_q};
				end
			end
			ST_PAD: begin
				ram_we    = 1'b1;
				ram_waddr = wptr_q;
				if (first_q) begin
					ram_wdata = pad_word;
				end else if (!extra_q && wptr_q == BUF_AW'(BUF_WORDS - 2)) begin
					ram_wdata = bits_q[31:0];
				end else if (!extra_q && wptr_q == BUF_AW'(BUF_WORDS - 1)) begin
					ram_wdata = bits_q[63:32];
				end
			end
			ST_LOAD: begin
				ram_ra = WL[0];
				ram_rb = WR[0];
			end
			ST_COMP: begin
				ram_ra = WL[rnd_rd];
				ram_rb = WR[rnd_rd];
			end
			default: ;
		endcase
	end

	// control state, bit count and chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			bits_q    <= '0;
			wptr_q    <= '0;
			first_q   <= 1'b0;
			extra_q   <= 1'b0;
			fin_q     <= 1'b0;
			lendone_q <= 1'b0;
			rnd_q     <= '0;
			oidx_q    <= '0;
			out_vld_q <= 1'b0;
			for (int i = 0; i < DIG_WORDS; i++) begin
				chain_q[i] <= IV[i];
			end
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (msg.has_byte) begin
							bits_q <= bits_q + 64'd8;
						end
						pos_q     <= new_pos;
						fin_q     <= msg.last_byte;
						first_q   <= 1'b1;
						lendone_q <= 1'b0;
						wptr_q    <= new_pos[5:2];
						// no room for the length after the 0x80 byte
						extra_q   <= (new_pos >= 6'd56);
					end
				end
				ST_PAD: begin
					wptr_q  <= wptr_q + 1'b1;
					first_q <= 1'b0;
					if (wptr_q == BUF_AW'(BUF_WORDS - 1)) begin
						if (extra_q) begin
							extra_q <= 1'b0;
						end else begin
							lendone_q <= 1'b1;
						end
					end
				end
				ST_LOAD: rnd_q <= '0;
				ST_COMP: rnd_q <= rnd_q + 1'b1;
				ST_FIN: begin
					chain_q[0] <= chain_q[1] + left_q.c + right_q.d;
					chain_q[1] <= chain_q[2] + left_q.d + right_q.e;
					chain_q[2] <= chain_q[3] + left_q.e + right_q.a;
					chain_q[3] <= chain_q[4] + left_q.a + right_q.b;
					chain_q[4] <= chain_q[0] + left_q.b + right_q.c;
					oidx_q     <= '0;
				end
				ST_OUT: begin
					if (load_out) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'(DIG_WORDS - 1)) begin
							// ready for the next message
							pos_q  <= '0;
							bits_q <= '0;
							fin_q  <= 1'b0;
							for (int i = 0; i < DIG_WORDS; i++) begin
								chain_q[i] <= IV[i];
							end
						end
					end
				end
				default: ;
			endcase
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (!dig_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept && msg.has_byte) begin
			case (pos_q[1:0])
				2'd0: acc_q[7:0]   <= msg.data_byte;
				2'd1: acc_q[15:8]  <= msg.data_byte;
				2'd2: acc_q[23:16] <= msg.data_byte;
				default: ;
			endcase
		end
		if (state_q == ST_LOAD) begin
			left_q  <= '{a: chain_q[0], b: chain_q[1], c: chain_q[2], d: chain_q[3],
				e: chain_q[4]};
			right_q <= '{a: chain_q[0], b: chain_q[1], c: chain_q[2], d: chain_q[3],
				e: chain_q[4]};
		end else if (state_q == ST_COMP) begin
			left_q  <= left_nxt;
			right_q <= right_nxt;
		end
		if (load_out) begin
			out_q.digest_word <= chain_q[oidx_q];
			out_q.word_index  <= oidx_q;
			out_q.last_word   <= (oidx_q == 3'(DIG_WORDS - 1));
		end
	end

`ifndef SYNTHESIS
	// the byte that fills the block starts a compression
	a_full_starts: assert property (@(posedge clk) disable iff (!arst_n)
		blk_full |=> state_q == ST_LOAD)
		else $error("full block did not start compression");

	// the length block is written before the digest leaves
	a_len_written: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PAD && !extra_q && wptr_q == BUF_AW'(BUF_WORDS - 1) |=> lendone_q)
		else $error("length words not marked written");

	a_out_after_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |-> lendone_q && fin_q)
		else $error("digest output without finished padding");

	// the final word carries the last index
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && dig.last_word |-> dig.word_index == 3'(DIG_WORDS - 1))
		else $error("last word flag on wrong index");
`endif

endmodule

@@ sim/tb_ripemd160_hash_engine_top.sv @@
// tb_ripemd160_hash_engine_top: self-checking bench for the byte-stream ripemd-160 engine
// depends on rmd_pkg (msg_t, dig_t) and ripemd160_hash_engine_top; carries its own hash model
// directed messages first, then random messages under four idle/stall mixes

`timescale 1ns / 1ps

module tb_ripemd160_hash_engine_top
	import rmd_pkg::*;
();

	// no accepted item for this many cycles ends the run; the slowest legal gap is
	// an ending item that needs a length block plus a long stall run
	localparam int WATCHDOG_LIMIT = 3000;
	// quiet cycles after the last digest word, enough for a two-block finish
	localparam int TAIL_CYCLES    = 400;

	// message word order of each step, left and right line, one nibble per step
	localparam logic [0:79][3:0] WSEL_L = {
		64'h0123456789abcdef, 64'h74d1a6f3c0952eb8, 64'h3ae49f812706db5c,
		64'h19ba08c4d37fe562, 64'h40597c2ae138b6fd};
	localparam logic [0:79][3:0] WSEL_R = {
		64'h5e7092b4d6f81a3c, 64'h6b370d5aef8c4912, 64'hf5137e69b8c2a04d,
		64'h86413bf05c2d97ae, 64'hcfa4158762de039b};
	// rotate amounts of each step
	localparam logic [0:79][3:0] ROT_L = {
		64'hbefc5879bdef6798, 64'h768db97f7cf9b7dc, 64'hbd67e9dfe8d65c75,
		64'hbcefef989e56865c, 64'h9f5b68dc5cdeb856};
	localparam logic [0:79][3:0] ROT_R = {
		64'h899bdff5778beec6, 64'h9df7c89b77c76fdb, 64'h97fb866ecd5edd75,
		64'hf58bee6e69c9c5f8, 64'h85c9c5e68d65fdbb};
	// additive constants of each group of sixteen steps
	localparam logic [0:4][31:0] ADD_L = {
		32'h00000000, 32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hA953FD4E};
	localparam logic [0:4][31:0] ADD_R = {
		32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3, 32'h7A6D76E9, 32'h00000000};
	localparam logic [0:4][31:0] CHAIN_INIT = {
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic msg_valid = 1'b0;
	logic msg_stall;
	msg_t msg       = '0;
	logic dig_valid;
	logic dig_stall = 1'b0;
	dig_t dig;

	// hash model state: chaining words, pending block bytes, fill level, length in bits
	logic [31:0] chain_q [5];
	logic [7:0]  blk_q [64];
	int unsigned fill_q;
	logic [63:0] len_bits_q;

	dig_t digest_q [$];       // digest words still owed by the engine, oldest first

	int send_idle_pct = 0;    // chance per cycle that the sender holds off
	int recv_stall_pct = 0;   // chance per cycle that the receiver stalls
	int mismatches = 0;
	int msg_items = 0;        // items that carry a byte or end a message, plus every directed item
	int quiet_cycles = 0;

	ripemd160_hash_engine_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg       (msg),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.dig       (dig)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// hash model
	// ------------------------------------------------------------------

	function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
		return (x << n) | (x >> (32 - n));
	endfunction

	// boolean function of one step group; the right line walks the groups backwards
	function automatic logic [31:0] step_mix(input int unsigned grp, input logic [31:0] x,
			input logic [31:0] y, input logic [31:0] z);
		logic [31:0] f;
		case (grp)
			0: f = x ^ y ^ z;
			1: f = (x & y) | (~x & z);
			2: f = (x | ~y) ^ z;
			3: f = (x & z) | (y & ~z);
			default: f = x ^ (y | ~z);
		endcase
		return f;
	endfunction

	function automatic void chain_reset();
		for (int j = 0; j < 5; j++)
			chain_q[j] = CHAIN_INIT[j];
		fill_q = 0;
		len_bits_q = '0;
	endfunction

	// two parallel lines of 80 steps over the pending block, then the chaining update
	function automatic void compress_block();
		logic [31:0] w [16];
		logic [31:0] al, bl, cl, dl, el, ar, br, cr, dr, er, t;
		int unsigned grp;
		for (int i = 0; i < 16; i++)
			w[i] = {blk_q[4*i+3], blk_q[4*i+2], blk_q[4*i+1], blk_q[4*i]};
		al = chain_q[0]; bl = chain_q[1]; cl = chain_q[2]; dl = chain_q[3]; el = chain_q[4];
		ar = al; br = bl; cr = cl; dr = dl; er = el;
		for (int i = 0; i < 80; i++) begin
			grp = i / 16;
			t = rol32(al + step_mix(grp, bl, cl, dl) + w[WSEL_L[i]] + ADD_L[grp], ROT_L[i]) + el;
			al = el; el = dl; dl = rol32(cl, 10); cl = bl; bl = t;
			t = rol32(ar + step_mix(4 - grp, br, cr, dr) + w[WSEL_R[i]] + ADD_R[grp],
				ROT_R[i]) + er;
			ar = er; er = dr; dr = rol32(cr, 10); cr = br; br = t;
		end
		t          = chain_q[1] + cl + dr;
		chain_q[1] = chain_q[2] + dl + er;
		chain_q[2] = chain_q[3] + el + ar;
		chain_q[3] = chain_q[4] + al + br;
		chain_q[4] = chain_q[0] + bl + cr;
		chain_q[0] = t;
	endfunction

	// take one accepted item; an ending item pads, finishes and queues the five digest words
	function automatic void absorb_item(input msg_t m);
		int unsigned p;
		dig_t d;
		if (m.has_byte) begin
			blk_q[fill_q] = m.data_byte;
			len_bits_q += 64'd8;
			fill_q++;
			if (fill_q == 64) begin
				compress_block();
				fill_q = 0;
			end
		end
		if (m.last_byte) begin
			p = fill_q;
			blk_q[p] = 8'h80;
			p++;
			// no room left for the length field: finish this block, length goes in a new one
			if (p > 56) begin
				while (p < 64) begin
					blk_q[p] = 8'h00;
					p++;
				end
				compress_block();
				p = 0;
			end
			while (p < 56) begin
				blk_q[p] = 8'h00;
				p++;
			end
			for (int j = 0; j < 8; j++)
				blk_q[56+j] = len_bits_q[8*j +: 8];
			compress_block();
			for (int j = 0; j < 5; j++) begin
				d.digest_word = chain_q[j];
				d.word_index  = 3'(j);
				d.last_word   = (j == 4);
				digest_q.push_back(d);
			end
			chain_reset();
		end
	endfunction

	// ------------------------------------------------------------------
	// digest side: check every accepted word, then pick the next stall
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		dig_t want;
		if (arst_n && dig_valid && !dig_stall) begin
			if (digest_q.size() == 0) begin
				$display("%0t: digest word with none expected, got %h index %0d last %b",
					$time, dig.digest_word, dig.word_index, dig.last_word);
				mismatches++;
			end else begin
				want = digest_q.pop_front();
				if (dig.digest_word !== want.digest_word) begin
					$display("%0t: digest_word expected %h, got %h",
						$time, want.digest_word, dig.digest_word);
					mismatches++;
				end
				if (dig.word_index !== want.word_index) begin
					$display("%0t: word_index expected %0d, got %0d",
						$time, want.word_index, dig.word_index);
					mismatches++;
				end
				if (dig.last_word !== want.last_word) begin
					$display("%0t: last_word expected %b, got %b",
						$time, want.last_word, dig.last_word);
					mismatches++;
				end
			end
		end
		dig_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// watchdog: counts cycles without any accepted item on either side
	always @(posedge clk) begin
		if (!arst_n || (msg_valid && !msg_stall) || (dig_valid && !dig_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("tb_ripemd160_hash_engine_top NOT OK");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// message side
	// ------------------------------------------------------------------

	// offer one item, holding off at random first; valid stays high after the
	// handshake, so between back-to-back items valid drops only when the sender holds off
	task automatic send_msg_item(input msg_t m);
		while ($urandom_range(99) < send_idle_pct) begin
			msg_valid <= 1'b0;
			@(posedge clk);
		end
		msg_valid <= 1'b1;
		msg       <= m;
		@(posedge clk);
		while (msg_stall)
			@(posedge clk);
		absorb_item(m);
	endtask

	// one message of len bytes with the odd no-byte item mixed in; the end flag rides
	// either on the final byte or on a separate item without a byte
	task automatic send_message(input int unsigned len, input int noise_pct);
		msg_t m;
		bit tail_on_byte;
		tail_on_byte = (len != 0) && ($urandom_range(1) == 1);
		for (int unsigned k = 0; k < len; k++) begin
			if ($urandom_range(99) < noise_pct) begin
				m.data_byte = 8'($urandom);
				m.has_byte  = 1'b0;
				m.last_byte = 1'b0;
				send_msg_item(m);
			end
			m.data_byte = 8'($urandom);
			m.has_byte  = 1'b1;
			m.last_byte = tail_on_byte && (k == len - 1);
			send_msg_item(m);
			msg_items++;
		end
		if (!tail_on_byte) begin
			m.data_byte = 8'($urandom);
			m.has_byte  = 1'b0;
			m.last_byte = 1'b1;
			send_msg_item(m);
			msg_items++;
		end
	endtask

	// sender goes quiet until the engine has delivered every owed digest word
	task automatic hold_until_digests_drained();
		msg_valid <= 1'b0;
		@(posedge clk);
		while (digest_q.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	task automatic test_directed_cases();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		// empty message; the data byte of an ending item without a byte is ignored
		send_msg_item('{data_byte: 8'hA5, has_byte: 1'b0, last_byte: 1'b1});
		// "abc", end flag on the last byte
		send_msg_item('{data_byte: 8'h61, has_byte: 1'b1, last_byte: 1'b0});
		send_msg_item('{data_byte: 8'h62, has_byte: 1'b1, last_byte: 1'b0});
		send_msg_item('{data_byte: 8'h63, has_byte: 1'b1, last_byte: 1'b1});
		// zero byte, an item without a byte that changes nothing, then all-ones as last byte
		send_msg_item('{data_byte: 8'h00, has_byte: 1'b1, last_byte: 1'b0});
		send_msg_item('{data_byte: 8'hFF, has_byte: 1'b0, last_byte: 1'b0});
		send_msg_item('{data_byte: 8'hFF, has_byte: 1'b1, last_byte: 1'b1});
		// single byte closed by an ending item without a byte
		send_msg_item('{data_byte: 8'h78, has_byte: 1'b1, last_byte: 1'b0});
		send_msg_item('{data_byte: 8'h5A, has_byte: 1'b0, last_byte: 1'b1});
		// all-ones byte closed by a separate ending item that also carries all-ones data
		send_msg_item('{data_byte: 8'hFF, has_byte: 1'b1, last_byte: 1'b0});
		send_msg_item('{data_byte: 8'hFF, has_byte: 1'b0, last_byte: 1'b1});
		msg_items += 11;
	endtask

	// random messages; lengths bunch at the padding boundary (55, 56, 63, 64 bytes)
	// where the extra length block and full-block compressions happen
	task automatic test_random_messages(input int idle_pct, input int stall_pct,
			input int item_budget);
		int start_items;
		int unsigned len;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		start_items    = msg_items;
		while (msg_items - start_items < item_budget) begin
			case ($urandom_range(19))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9: len = $urandom_range(8);
				10, 11, 12, 13, 14, 15: len = $urandom_range(53, 66);
				16, 17, 18: len = $urandom_range(9, 52);
				default: len = $urandom_range(118, 130);
			endcase
			send_message(len, 8);
		end
	endtask

	initial begin
		chain_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// the last message of each phase may overshoot its item budget
		test_directed_cases();
		hold_until_digests_drained();
		test_random_messages(0, 0, 20);
		test_random_messages(84, 0, 20);
		hold_until_digests_drained();
		test_random_messages(0, 84, 20);
		test_random_messages(36, 36, 20);

		// wind down: nothing left to send, wait for the last digest, then watch for strays
		hold_until_digests_drained();
		recv_stall_pct = 0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && digest_q.size() == 0)
			$display("tb_ripemd160_hash_engine_top OK");
		else
			$display("tb_ripemd160_hash_engine_top NOT OK");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/rmd_pkg.sv
rtl/core/rmd_ram.sv
rtl/core/rmd_round.sv
rtl/core/ripemd160_hash_engine_top.sv
sim/tb_ripemd160_hash_engine_top.sv
